@@ rtl/kce_pkg.sv @@
// ----------------------------------------------------------------------------
// kce_pkg
// Key codes, pending operation codes and sequencer states for the keypad
// calculator engine.
// ----------------------------------------------------------------------------
package kce_pkg;

  localparam int KEY_BITS = 4;

  // key codes
  localparam logic [3:0] KEY_DIGIT  = 4'd0;
  localparam logic [3:0] KEY_ADD    = 4'd1;
  localparam logic [3:0] KEY_SUB    = 4'd2;
  localparam logic [3:0] KEY_MUL    = 4'd3;
  localparam logic [3:0] KEY_DIV    = 4'd4;
  localparam logic [3:0] KEY_MOD    = 4'd5;
  localparam logic [3:0] KEY_POW    = 4'd6;
  localparam logic [3:0] KEY_EQUALS = 4'd7;
  localparam logic [3:0] KEY_CLR    = 4'd8;
  localparam logic [3:0] KEY_CE     = 4'd9;
  localparam logic [3:0] KEY_BACK   = 4'd10;
  localparam logic [3:0] KEY_SIGN   = 4'd11;
  localparam logic [3:0] KEY_MS     = 4'd12;
  localparam logic [3:0] KEY_MR     = 4'd13;
  localparam logic [3:0] KEY_MC     = 4'd14;
  localparam logic [3:0] KEY_MADD   = 4'd15;

  // pending operation codes
  localparam logic [2:0] OP_LOAD = 3'd0;
  localparam logic [2:0] OP_ADD  = 3'd1;
  localparam logic [2:0] OP_SUB  = 3'd2;
  localparam logic [2:0] OP_MUL  = 3'd3;
  localparam logic [2:0] OP_DIV  = 3'd4;
  localparam logic [2:0] OP_MOD  = 3'd5;
  localparam logic [2:0] OP_POW  = 3'd6;

  typedef enum logic [6:0] {
    ST_IDLE = 7'b0000001,
    ST_MUL  = 7'b0000010,
    ST_DIV  = 7'b0000100,
    ST_POWM = 7'b0001000,
    ST_BACK = 7'b0010000,
    ST_FOLD = 7'b0100000,
    ST_OUT  = 7'b1000000
  } state_t;

  typedef struct packed {
    logic [3:0] key_kind;
    logic [3:0] digit;
  } key_t;

endpackage

@@ rtl/kce_if.sv @@
// ----------------------------------------------------------------------------
// kce_if
// Valid/ready channel carrying one payload of parameterised type.
// ----------------------------------------------------------------------------
interface kce_if #(parameter type T = logic);
  logic valid;
  logic ready;
  T     data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

@@ rtl/kce_out_if.sv @@
// ----------------------------------------------------------------------------
// kce_out_if
// Valid/ready result channel: display value, memory mark and error bit.
// ----------------------------------------------------------------------------
interface kce_out_if #(parameter int WORD_BITS = 32);
  logic                        valid;
  logic                        ready;
  logic signed [WORD_BITS-1:0] display_value;
  logic                        memory_marked;
  logic                        error;
  modport source (output valid, output display_value, output memory_marked,
                  output error, input ready);
  modport sink (input valid, input display_value, input memory_marked,
                input error, output ready);
endinterface

@@ rtl/keypad_calculator_engine.sv @@
// ----------------------------------------------------------------------------
// keypad_calculator_engine
// Four-function keypad calculator with power, remainder and memory.
// ----------------------------------------------------------------------------
// One key is taken at a time and gives one result. Keys that only edit the
// entry or the memory go straight to the result; an operator or equals that
// needs no serial step, and memory add, pass through the fold state first.
// Multiply is a bit-serial shift-add, divide and remainder use a restoring
// divider (one quotient bit a cycle), backspace is a serial divide by ten,
// and power runs one serial multiply per factor: a base of two or more
// saturates by the WORD_BITS-th factor. The next key is accepted once the
// result register is free.
module keypad_calculator_engine #(
  parameter int WORD_BITS = 32
) (
  input logic clk,
  input logic rst,
  kce_if.sink      key_in,
  kce_out_if.source res_out
);
  import kce_pkg::*;

  localparam int W  = WORD_BITS;
  localparam int CB = $clog2(W + 2);

  localparam logic [W-1:0] SIGNB = {1'b1, {(W-1){1'b0}}};
  localparam logic [W-1:0] SMAX  = {1'b0, {(W-1){1'b1}}};
  localparam logic [W-1:0] ONE   = {{(W-1){1'b0}}, 1'b1};
  localparam logic [W-1:0] ZERO  = '0;
  localparam logic [W-1:0] TEN   = {{(W-4){1'b0}}, 4'd10};

  state_t state;

  // architectural state
  logic [W-1:0] entry_value, accumulator, memory_value;
  logic         entry_negative, fresh_entry, after_equals, memory_flag;
  logic [2:0]   pending_op;

  // working registers
  logic [3:0]   kind;
  logic [W-1:0] opa, opb;          // operand magnitudes / raw words
  logic [W:0]   prod;              // serial product (W+1 bits for saturation)
  logic [W-1:0] mcand, mplier;
  logic [W-1:0] quo, rem_r, dvd;
  logic [CB-1:0] cnt;
  logic [CB:0]  pcnt;              // power iteration count
  logic         psat, rneg, errf;
  logic [W-1:0] fold_res;
  logic         fold_ok;

  logic         out_valid;
  logic [W-1:0] out_disp;
  logic         out_err;

  // combinational helpers
  logic [W-1:0] ent_word, op_a, op_b, mag_a, mag_b;
  logic [3:0]   dsat;
  logic [W:0]   trial;
  logic [W+3:0] ext10;

  always_comb begin
    if (entry_negative) ent_word = ZERO - entry_value;
    else if (entry_value > SMAX) ent_word = SMAX;
    else ent_word = entry_value;
    dsat  = (key_in.data.digit > 4'd9) ? 4'd9 : key_in.data.digit;
    mag_a = accumulator[W-1] ? ZERO - accumulator : accumulator;
    mag_b = ent_word[W-1] ? ZERO - ent_word : ent_word;
    op_a  = accumulator;
    op_b  = ent_word;
    trial = {rem_r, dvd[W-1]} - {1'b0, opb};
    // digit append: entry*10 + d on W+4 bits
    ext10 = {4'd0, entry_value} * (W + 4)'(10) + (W + 4)'(dsat);
  end

  assign key_in.ready          = (state == ST_IDLE) && !out_valid;
  assign res_out.valid         = out_valid;
  assign res_out.display_value = out_disp;
  assign res_out.memory_marked = memory_flag;
  assign res_out.error         = out_err;

  // main sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      entry_value <= '0; entry_negative <= 1'b0; accumulator <= '0;
      pending_op <= OP_LOAD; fresh_entry <= 1'b0; after_equals <= 1'b0;
      memory_value <= '0; memory_flag <= 1'b0;
      out_valid <= 1'b0; out_err <= 1'b0; errf <= 1'b0;
    end else begin
      if (out_valid && res_out.ready) out_valid <= 1'b0;
      case (state)
        ST_IDLE: begin
          if (key_in.valid && key_in.ready) begin
            kind <= key_in.data.key_kind;
            errf <= 1'b0;
            state <= ST_OUT;
            case (key_in.data.key_kind)
              KEY_DIGIT: begin
                if (after_equals || fresh_entry) begin
                  if (after_equals) begin
                    accumulator <= '0; pending_op <= OP_LOAD;
                    after_equals <= 1'b0;
                  end
                  entry_value <= W'(dsat); entry_negative <= 1'b0;
                end else if (ext10 > {4'd0, SIGNB}) entry_value <= SIGNB;
                else entry_value <= ext10[W-1:0];
                fresh_entry <= 1'b0;
              end
              KEY_ADD, KEY_SUB, KEY_MUL, KEY_DIV, KEY_MOD, KEY_POW,
              KEY_EQUALS: begin
                if (after_equals) begin
                  // clear all first, then fold loads the (now zero) entry
                  entry_value <= '0; entry_negative <= 1'b0;
                  accumulator <= '0; fresh_entry <= 1'b0;
                  pending_op <= OP_LOAD; after_equals <= 1'b0;
                  fold_res <= '0; fold_ok <= 1'b1;
                  state <= ST_FOLD;
                end else if (fresh_entry) begin
                  state <= ST_FOLD; fold_ok <= 1'b0;
                end else begin
                  fold_ok <= 1'b1;
                  case (pending_op)
                    OP_ADD: begin fold_res <= op_a + op_b; state <= ST_FOLD; end
                    OP_SUB: begin fold_res <= op_a - op_b; state <= ST_FOLD; end
                    OP_MUL: begin
                      mcand <= op_a; mplier <= op_b; prod <= '0;
                      cnt <= '0; state <= ST_MUL;
                    end
                    OP_DIV, OP_MOD: begin
                      if (mag_b == ZERO) begin
                        errf <= 1'b1; fold_res <= op_a; state <= ST_FOLD;
                      end else begin
                        opb <= mag_b; dvd <= mag_a; rem_r <= '0; quo <= '0;
                        cnt <= '0; state <= ST_DIV;
                      end
                    end
                    OP_POW: begin
                      rneg <= op_a[W-1] & op_b[0];
                      opa <= mag_a; opb <= op_b;
                      if (op_b[W-1]) begin
                        fold_res <= (mag_a == ZERO) ? SMAX :
                                    (mag_a == ONE) ? ((op_a[W-1] & op_b[0]) ?
                                    {W{1'b1}} : ONE) : ZERO;
                        state <= ST_FOLD;
                      end else if (op_b == ZERO) begin
                        fold_res <= ONE; state <= ST_FOLD;
                      end else if (mag_a == ZERO) begin
                        fold_res <= ZERO; state <= ST_FOLD;
                      end else begin
                        pcnt <= '0; psat <= 1'b0;
                        mcand <= ONE; mplier <= mag_a; prod <= '0;
                        cnt <= '0; state <= (mag_a == ONE) ? ST_FOLD : ST_POWM;
                        if (mag_a == ONE) fold_res <= (op_a[W-1] & op_b[0]) ?
                                                      {W{1'b1}} : ONE;
                      end
                    end
                    default: begin fold_res <= op_b; state <= ST_FOLD; end
                  endcase
                end
              end
              KEY_CLR: begin
                entry_value <= '0; entry_negative <= 1'b0; fresh_entry <= 1'b0;
                accumulator <= '0; pending_op <= OP_LOAD;
              end
              KEY_CE: begin entry_value <= '0; entry_negative <= 1'b0; end
              KEY_BACK: begin
                if (entry_value == ZERO) entry_negative <= 1'b0;
                else begin
                  opb <= TEN; dvd <= entry_value; rem_r <= '0; quo <= '0;
                  cnt <= '0; state <= ST_BACK;
                end
              end
              KEY_SIGN: entry_negative <= ~entry_negative;
              KEY_MS: begin memory_value <= ent_word; memory_flag <= 1'b1; end
              KEY_MR: begin
                entry_negative <= memory_value[W-1];
                entry_value <= memory_value[W-1] ? ZERO - memory_value : memory_value;
              end
              KEY_MC: begin memory_value <= '0; memory_flag <= 1'b0; end
              default: begin
                memory_value <= memory_value + ent_word;
                state <= ST_FOLD; fold_ok <= 1'b0;
              end
            endcase
          end
        end
        // shift-add multiply, one multiplier bit a cycle
        ST_MUL: begin
          if (mplier[0]) prod <= {1'b0, prod[W-1:0] + mcand};
          mcand <= mcand << 1; mplier <= mplier >> 1;
          cnt <= cnt + 1'b1;
          if (cnt == CB'(W - 1)) begin
            fold_res <= mplier[0] ? prod[W-1:0] + mcand : prod[W-1:0];
            state <= ST_FOLD;
          end
        end
        // restoring divide, one quotient bit a cycle
        ST_DIV, ST_BACK: begin
          dvd <= dvd << 1;
          if (!trial[W]) begin
            rem_r <= trial[W-1:0]; quo <= {quo[W-2:0], 1'b1};
          end else begin
            rem_r <= {rem_r[W-2:0], dvd[W-1]}; quo <= {quo[W-2:0], 1'b0};
          end
          cnt <= cnt + 1'b1;
          if (cnt == CB'(W - 1)) begin
            if (state == ST_BACK) begin
              entry_value <= !trial[W] ? {quo[W-2:0], 1'b1} : {quo[W-2:0], 1'b0};
              state <= ST_OUT;
            end else begin
              state <= ST_FOLD;
              if (pending_op == OP_DIV) begin
                fold_res <= (accumulator[W-1] != ent_word[W-1]) ?
                  ZERO - (!trial[W] ? {quo[W-2:0], 1'b1} : {quo[W-2:0], 1'b0}) :
                  (!trial[W] ? {quo[W-2:0], 1'b1} : {quo[W-2:0], 1'b0});
              end else begin
                fold_res <= accumulator[W-1] ?
                  ZERO - (!trial[W] ? trial[W-1:0] : {rem_r[W-2:0], dvd[W-1]}) :
                  (!trial[W] ? trial[W-1:0] : {rem_r[W-2:0], dvd[W-1]});
              end
            end
          end
        end
        // power: repeated serial multiply of the running power by the base
        ST_POWM: begin
          if (mplier[0]) prod <= prod + {1'b0, mcand};
          mcand <= mcand << 1; mplier <= mplier >> 1;
          if (mcand[W-1] && (mplier >> 1) != ZERO) psat <= 1'b1;
          if (mplier[0] && ((prod + {1'b0, mcand}) > {1'b0, SIGNB})) psat <= 1'b1;
          cnt <= cnt + 1'b1;
          if (cnt == CB'(W - 1)) begin
            logic [W:0] pn;
            pn = mplier[0] ? prod + {1'b0, mcand} : prod;
            pcnt <= pcnt + 1'b1;
            if (psat || pn > {1'b0, SIGNB} ||
                (mplier[0] && ((prod + {1'b0, mcand}) > {1'b0, SIGNB}))) begin
              fold_res <= rneg ? SIGNB : SMAX; state <= ST_FOLD;
            end else if ((CB+1)'(pcnt + 1'b1) == (CB+1)'(opb) ||
                         opb[W-1:CB] != '0 && pcnt == (CB+1)'(W)) begin
              if (pcnt + 1'b1 == (CB+1)'(opb) && opb[W-1:CB] == '0) begin
                fold_res <= rneg ? ZERO - pn[W-1:0] :
                            (pn[W-1] ? SMAX : pn[W-1:0]);
              end else begin
                fold_res <= rneg ? SIGNB : SMAX;
              end
              state <= ST_FOLD;
            end else begin
              mcand <= pn[W-1:0]; mplier <= opa; prod <= '0; cnt <= '0; psat <= 1'b0;
            end
          end
        end
        ST_FOLD: begin
          if (kind != KEY_MADD) begin
            if (fold_ok) begin
              accumulator <= fold_res;
              entry_negative <= fold_res[W-1];
              entry_value <= fold_res[W-1] ? ZERO - fold_res : fold_res;
            end
            pending_op <= (kind == KEY_EQUALS) ? pending_op : kind[2:0];
            fresh_entry <= 1'b1;
            if (kind == KEY_EQUALS) after_equals <= 1'b1;
          end else begin
            entry_negative <= memory_value[W-1];
            entry_value <= memory_value[W-1] ? ZERO - memory_value : memory_value;
          end
          state <= ST_OUT;
        end
        ST_OUT: begin
          if (!out_valid) begin
            out_valid <= 1'b1; out_disp <= ent_word; out_err <= errf;
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

`ifndef ASSERT_OFF
  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (state != ST_IDLE) |-> !key_in.ready) else $error("key taken while busy");
  a_err_div: assert property (@(posedge clk) disable iff (rst)
    (res_out.valid && res_out.error) |-> (pending_op == OP_DIV ||
     pending_op == OP_MOD || after_equals || fresh_entry))
    else $error("error without divide");
  a_flag_mc: assert property (@(posedge clk) disable iff (rst)
    (key_in.valid && key_in.ready && key_in.data.key_kind == KEY_MC) |=>
    !memory_flag) else $error("memory clear kept mark");
`endif

endmodule
